// ===== rtl/lse_pkg.sv =====
// Shared types and constants for the LSB steganography extractor.
// No dependencies; used by every module in rtl/.
package lse_pkg;

  localparam int HEADER_BYTES_DEF = 4;
  localparam int QUEUE_DEPTH_DEF  = 4;
  localparam int APB_ADDR_W       = 4;

  localparam logic [1:0] REG_LSB_WIDTH_LOG2 = 2'd0;
  localparam logic [1:0] REG_ENCRYPTED      = 2'd1;
  localparam logic [1:0] REG_COVER_SIZE     = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER    = 2'd0,
    PH_PAYLOAD   = 2'd1,
    PH_EXTENSION = 2'd2,
    PH_DONE      = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_LENGTH     = 2'd0,
    KIND_PAYLOAD    = 2'd1,
    KIND_EXTENSION  = 2'd2,
    KIND_TERMINATOR = 2'd3
  } kind_t;

  typedef struct packed {
    logic       restart;
    logic       has_byte;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic [7:0] hidden_byte;
    kind_t      kind;
    logic       bad_length;
    logic       last;
  } result_t;

endpackage

// ===== rtl/lse_front.sv =====
// Front end: accepts cover bytes and gathers their low bits into hidden bytes.
// Depends on lse_pkg; feeds lse_queue.
module lse_front
  import lse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [7:0] cover_byte,
  input  logic       restart,
  input  logic [1:0] lsb_width_log2,
  input  logic       queue_full,
  output logic       push,
  output entry_t     push_entry
);

  logic [7:0] assembly;
  logic [2:0] sub_count;
  logic [7:0] base_asm;
  logic [2:0] base_sc;
  logic [7:0] shifted;
  logic [2:0] sc_inc;
  logic [3:0] groups;
  logic       complete;
  logic       accept;

  assign s_ready = !queue_full;
  assign accept  = s_valid && s_ready;

  always_comb begin
    base_asm = restart ? 8'd0 : assembly;
    base_sc  = restart ? 3'd0 : sub_count;
    unique case (lsb_width_log2)
      2'd0: shifted = {base_asm[6:0], cover_byte[0]};
      2'd1: shifted = {base_asm[5:0], cover_byte[1:0]};
      2'd2: shifted = {base_asm[3:0], cover_byte[3:0]};
      default: shifted = cover_byte;
    endcase
    sc_inc   = base_sc + 3'd1;
    groups   = 4'd8 >> lsb_width_log2;
    complete = (sc_inc == 3'd0) || ({1'b0, sc_inc} >= groups);
  end

  assign push                = accept && (restart || complete);
  assign push_entry.restart  = restart;
  assign push_entry.has_byte = complete;
  assign push_entry.data     = shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      assembly  <= 8'd0;
      sub_count <= 3'd0;
    end else if (accept) begin
      if (complete) begin
        assembly  <= 8'd0;
        sub_count <= 3'd0;
      end else begin
        assembly  <= shifted;
        sub_count <= sc_inc;
      end
    end
  end

endmodule

// ===== rtl/lse_queue.sv =====
// Small queue of hidden-byte entries between front and back.
// Depends on lse_pkg.
module lse_queue
  import lse_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lse_back.sv =====
// Back end: frames hidden bytes into length, payload and extension results.
// Depends on lse_pkg; drains lse_queue and drives the result register.
module lse_back
  import lse_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        entry_valid,
  input  entry_t      entry,
  output logic        pop,
  input  logic [1:0]  lsb_width_log2,
  input  logic        encrypted,
  input  logic [31:0] cover_size,
  output logic        m_valid,
  input  logic        m_ready,
  output result_t     m_result
);

  localparam int HC_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam logic [HC_W-1:0] HC_LAST = HC_W'(HEADER_BYTES - 1);

  phase_t      phase, phase_next;
  logic [HC_W-1:0] header_count, header_count_next;
  logic [31:0] message_length, message_length_next;
  logic [31:0] payload_left, payload_left_next;
  result_t     res;
  logic        emit;
  phase_t      ph;
  logic [31:0] ml_shift;
  logic [31:0] pl_dec;
  logic [34:0] need;

  assign pop = entry_valid && (!m_valid || m_ready);

  always_comb begin
    ph                  = entry.restart ? PH_HEADER : phase;
    header_count_next   = entry.restart ? '0 : header_count;
    message_length_next = entry.restart ? 32'd0 : message_length;
    payload_left_next   = entry.restart ? 32'd0 : payload_left;
    phase_next          = ph;
    ml_shift            = {message_length_next[23:0], entry.data};
    pl_dec              = payload_left_next - 32'd1;
    need                = {3'b000, ml_shift} << (2'd3 - lsb_width_log2);
    emit                = 1'b0;
    res.hidden_byte     = entry.data;
    res.kind            = KIND_LENGTH;
    res.bad_length      = 1'b0;
    res.last            = 1'b0;
    if (entry.has_byte) begin
      unique case (ph)
        PH_HEADER: begin
          emit                = 1'b1;
          message_length_next = ml_shift;
          if (header_count_next == HC_LAST) begin
            if (need > {3'b000, cover_size}) begin
              phase_next     = PH_DONE;
              res.bad_length = 1'b1;
              res.last       = 1'b1;
            end else begin
              payload_left_next = ml_shift;
              if (ml_shift == 32'd0) begin
                phase_next = encrypted ? PH_DONE : PH_EXTENSION;
                res.last   = encrypted;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
          end else begin
            header_count_next = header_count_next + 1'b1;
          end
        end
        PH_PAYLOAD: begin
          emit              = 1'b1;
          res.kind          = KIND_PAYLOAD;
          payload_left_next = pl_dec;
          if (pl_dec == 32'd0) begin
            phase_next = encrypted ? PH_DONE : PH_EXTENSION;
            res.last   = encrypted;
          end
        end
        PH_EXTENSION: begin
          emit = 1'b1;
          if (entry.data == 8'd0) begin
            phase_next = PH_DONE;
            res.kind   = KIND_TERMINATOR;
            res.last   = 1'b1;
          end else begin
            res.kind = KIND_EXTENSION;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= '0;
      message_length <= 32'd0;
      payload_left   <= 32'd0;
    end else if (pop) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      message_length <= message_length_next;
      payload_left   <= payload_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (pop && emit) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      m_result <= res;
    end
  end

endmodule

// ===== rtl/lsb_stego_extractor_core.sv =====
// Top level of the LSB steganography extractor: APB registers, front, queue, back.
// Depends on lse_pkg, lse_front, lse_queue, lse_back.
//
// Channel  Dir  Handshake               Payload
// s_axis   in   tvalid/tready           tdata[7:0] cover_byte, tuser[0] restart
// m_axis   out  tvalid/tready           tdata[7:0] hidden_byte, tuser kind/bad_length, tlast
// apb      in   psel/penable/pready     registers at 0x0, 0x4, 0x8
//
// One cover byte per cycle unless the queue is full; results are queued, then registered.
// The front stalls only when the queue is full; the back stalls on m_axis_tready.
// Reset is synchronous; it clears framing state, the queue and the registers.
module lsb_stego_extractor_core
  import lse_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] cover_byte
  input  logic                  s_axis_tuser,   // [0] restart
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] hidden_byte
  output logic [2:0]            m_axis_tuser,   // [1:0] kind, [2] bad_length
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [1:0]  lsb_width_log2;
  logic        encrypted;
  logic [31:0] cover_size;
  logic        cfg_write;
  logic        push;
  entry_t      push_entry;
  logic        pop;
  logic        queue_full;
  logic        queue_valid;
  entry_t      head;
  result_t     result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_width_log2 <= 2'd0;
      encrypted      <= 1'b0;
      cover_size     <= 32'hFFFF_FFFF;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_LSB_WIDTH_LOG2: lsb_width_log2 <= pwdata[1:0];
        REG_ENCRYPTED:      encrypted      <= pwdata[0];
        REG_COVER_SIZE:     cover_size     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LSB_WIDTH_LOG2: prdata = {30'd0, lsb_width_log2};
      REG_ENCRYPTED:      prdata = {31'd0, encrypted};
      REG_COVER_SIZE:     prdata = cover_size;
      default:            prdata = 32'd0;
    endcase
  end

  lse_front u_front (
    .clk            (clk),
    .rst            (rst),
    .s_valid        (s_axis_tvalid),
    .s_ready        (s_axis_tready),
    .cover_byte     (s_axis_tdata),
    .restart        (s_axis_tuser),
    .lsb_width_log2 (lsb_width_log2),
    .queue_full     (queue_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  lse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (queue_valid),
    .head       (head)
  );

  lse_back #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .entry_valid    (queue_valid),
    .entry          (head),
    .pop            (pop),
    .lsb_width_log2 (lsb_width_log2),
    .encrypted      (encrypted),
    .cover_size     (cover_size),
    .m_valid        (m_axis_tvalid),
    .m_ready        (m_axis_tready),
    .m_result       (result)
  );

  assign m_axis_tdata = result.hidden_byte;
  assign m_axis_tuser = {result.bad_length, result.kind};
  assign m_axis_tlast = result.last;

endmodule
